// File: sv/dmg_pkg.sv
// shared constants and types of the division magic number generator
`timescale 1ns / 1ps

package dmg_pkg;

  // fixed field widths of the stream payload
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned SHIFT_W       = 5;
  localparam int unsigned OUT_TDATA_W   = 40;
  localparam int unsigned WORD_BITS_DEF = 32;

  // status of the shared subtractor
  typedef struct packed {
    logic ge;    // a >= b, no borrow
    logic zero;  // a == b
  } sub_flags_t;

endpackage

// File: sv/dmg_sub_unit.sv
// shared subtract and compare unit of the magic number sequencer
`timescale 1ns / 1ps

module dmg_sub_unit
  import dmg_pkg::*;
#(
  parameter int unsigned WIDTH = WORD_BITS_DEF + 1
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic [WIDTH-1:0] diff_o,
  output sub_flags_t       flags_o
);

  logic [WIDTH:0] full_diff;

  // extra top bit carries the borrow
  assign full_diff     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o        = full_diff[WIDTH-1:0];
  assign flags_o.ge    = ~full_diff[WIDTH];
  assign flags_o.zero  = (full_diff == '0);

endmodule

// File: sv/div_magic_number_gen_core.sv
// top level of the division magic number generator
`timescale 1ns / 1ps

// Takes one divisor per transaction on the slave stream (tdata = divisor,
// tuser = is_signed) and returns the multiplier, post shift and found flag
// that replace a division by that constant with a multiply and shift. All
// arithmetic runs through one shared subtract/compare unit stepped by a small
// sequencer, so the block takes one transaction at a time and drops
// s_axis_tready until the result is in the output register. An out-of-range
// divisor goes straight to the result; signed mode (W = WORD_BITS) runs two
// bit-serial divisions and then 1 to W search steps (q1/r1, q2/r2, delta,
// test); unsigned mode runs one division and then tests 1 to W candidate
// shifts. The single subtractor gives one quotient bit or one compare per
// cycle. The next divisor is taken while a finished result still waits on
// the master stream; a new result is only loaded once the previous one is
// taken.
module div_magic_number_gen_core
  import dmg_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // divisor stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // [31:0] divisor
  input  logic [0:0]             s_axis_tuser,   // [0] is_signed
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] multiplier, [36:32] post_shift,
                                                 // [39:37] zero
  output logic [0:0]             m_axis_tuser    // [0] found
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned ACC_W = W + 1;
  localparam int unsigned CNT_W = $clog2(W + 1);
  localparam int unsigned P_W   = $clog2(2 * W);

  localparam logic [P_W-1:0]   P_START   = P_W'(W - 1);      // signed search start
  localparam logic [P_W-1:0]   P_CAP     = P_W'(2 * W - 1);  // signed search bound
  localparam logic [P_W-1:0]   P_BASE    = P_W'(W);
  localparam logic [P_W-1:0]   S_LAST    = P_W'(W - 1);      // last unsigned shift
  localparam logic [CNT_W-1:0] CNT_HALF  = CNT_W'(W - 1);    // steps for 2^(W-1)/x
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(W);        // steps for 2^W/x
  localparam logic [ACC_W-1:0] HALF_M1   = {2'b00, {(W - 1){1'b1}}};
  localparam int unsigned      PAD_W     = OUT_TDATA_W - DATA_W - SHIFT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_D,     // 2^(W-1) / d, one quotient bit per cycle
    ST_ANC,       // anc = 2^(W-1) - 1 - 2^(W-1) mod d
    ST_DIV_A,     // 2^(W-1) / anc
    ST_SRCH_R1,   // signed search: q1/r1 step
    ST_SRCH_R2,   // signed search: q2/r2 step, p + 1
    ST_SRCH_DLT,  // delta = d - r2
    ST_SRCH_TST,  // loop test on q1 against delta
    ST_U_DIV,     // 2^W / d
    ST_U_TST,     // unsigned candidate test
    ST_U_STEP,    // next unsigned shift
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [P_W-1:0]   p_q;        // signed p, or unsigned shift s
  logic [W-1:0]     d_q;
  logic [W-1:0]     anc_q;
  logic [W-1:0]     delta_q;
  logic [ACC_W-1:0] qa_q;       // running quotient: q1, or unsigned Q
  logic [W-1:0]     ra_q;       // running remainder: r1, or unsigned R
  logic [W-1:0]     qb_q;       // q2 modulo 2^W
  logic [W-1:0]     rb_q;       // r2
  logic [W-1:0]     pow_q;      // one-hot 2^s for the unsigned error bound
  logic [W-1:0]     res_mult_q;
  logic [SHIFT_W-1:0] res_sh_q;
  logic             res_found_q;

  logic             m_valid_q;
  logic [DATA_W-1:0]  m_mult_q;
  logic [SHIFT_W-1:0] m_sh_q;
  logic             m_found_q;

  logic [ACC_W-1:0] unit_a;
  logic [ACC_W-1:0] unit_b;
  logic [ACC_W-1:0] unit_diff;
  sub_flags_t       unit_flags;

  logic             in_accept;
  logic             in_range;
  logic [W-1:0]     ra_next;
  logic [ACC_W-1:0] qa_next;
  logic [ACC_W-1:0] cand;
  logic             err_ok;
  logic             srch_cont;
  logic             out_free;

  // operand routing into the shared unit
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state_q)
      ST_DIV_D, ST_U_DIV, ST_U_STEP: begin
        unit_a = {ra_q, 1'b0};
        unit_b = {1'b0, d_q};
      end
      ST_DIV_A, ST_SRCH_R1: begin
        unit_a = {ra_q, 1'b0};
        unit_b = {1'b0, anc_q};
      end
      ST_ANC: begin
        unit_a = HALF_M1;
        unit_b = {1'b0, ra_q};
      end
      ST_SRCH_R2: begin
        unit_a = {rb_q, 1'b0};
        unit_b = {1'b0, d_q};
      end
      ST_SRCH_DLT: begin
        unit_a = {1'b0, d_q};
        unit_b = {1'b0, rb_q};
      end
      ST_SRCH_TST: begin
        unit_a = qa_q;
        unit_b = {1'b0, delta_q};
      end
      ST_U_TST: begin
        unit_a = {1'b0, d_q};
        unit_b = {1'b0, ra_q};
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  dmg_sub_unit #(
    .WIDTH(ACC_W)
  ) u_sub_unit (
    .a_i    (unit_a),
    .b_i    (unit_b),
    .diff_o (unit_diff),
    .flags_o(unit_flags)
  );

  // restoring division step: remainder stays below the divisor, so W bits hold it
  assign ra_next   = unit_flags.ge ? unit_diff[W-1:0] : unit_a[W-1:0];
  assign qa_next   = {qa_q[W-1:0], unit_flags.ge};

  // unsigned candidate ceil(2^(W+s)/d) and its rounding error d - R
  assign cand      = qa_q + ACC_W'(ra_q != '0);
  assign err_ok    = (ra_q == '0) || (unit_diff[W-1:0] < pow_q);

  // keep searching while q1 < delta, or q1 == delta with r1 == 0, and p < P_CAP
  assign srch_cont = (!unit_flags.ge || (unit_flags.zero && (ra_q == '0))) &&
                     (p_q < P_CAP);

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_range  = ((s_axis_tdata >> (W - 1)) == '0) && (s_axis_tdata > DATA_W'(1));
  assign out_free  = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      // a handover in ST_DONE reloads the output register in the same cycle
      if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            d_q  <= s_axis_tdata[W-1:0];
            ra_q <= W'(1);
            qa_q <= '0;
            if (!in_range) begin
              res_mult_q  <= '0;
              res_sh_q    <= '0;
              res_found_q <= 1'b0;
              state_q     <= ST_DONE;
            end else if (s_axis_tuser[0]) begin
              cnt_q   <= CNT_HALF;
              p_q     <= P_START;
              state_q <= ST_DIV_D;
            end else begin
              cnt_q   <= CNT_FULL;
              p_q     <= '0;
              pow_q   <= W'(1);
              state_q <= ST_U_DIV;
            end
          end
        end

        ST_DIV_D: begin
          ra_q  <= ra_next;
          qa_q  <= qa_next;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_ANC;
          end
        end

        ST_ANC: begin
          // park q2/r2, then divide again by anc
          anc_q   <= unit_diff[W-1:0];
          qb_q    <= qa_q[W-1:0];
          rb_q    <= ra_q;
          ra_q    <= W'(1);
          qa_q    <= '0;
          cnt_q   <= CNT_HALF;
          state_q <= ST_DIV_A;
        end

        ST_DIV_A: begin
          ra_q  <= ra_next;
          qa_q  <= qa_next;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_SRCH_R1;
          end
        end

        ST_SRCH_R1: begin
          ra_q    <= ra_next;
          qa_q    <= qa_next;
          state_q <= ST_SRCH_R2;
        end

        ST_SRCH_R2: begin
          rb_q    <= unit_flags.ge ? unit_diff[W-1:0] : unit_a[W-1:0];
          qb_q    <= {qb_q[W-2:0], unit_flags.ge};
          p_q     <= p_q + P_W'(1);
          state_q <= ST_SRCH_DLT;
        end

        ST_SRCH_DLT: begin
          delta_q <= unit_diff[W-1:0];
          state_q <= ST_SRCH_TST;
        end

        ST_SRCH_TST: begin
          if (srch_cont) begin
            state_q <= ST_SRCH_R1;
          end else begin
            res_mult_q  <= qb_q + W'(1);
            res_sh_q    <= SHIFT_W'(p_q - P_BASE);
            res_found_q <= 1'b1;
            state_q     <= ST_DONE;
          end
        end

        ST_U_DIV: begin
          ra_q  <= ra_next;
          qa_q  <= qa_next;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_U_TST;
          end
        end

        ST_U_TST: begin
          if (cand[W]) begin
            // candidate no longer fits the word
            res_mult_q  <= '0;
            res_sh_q    <= '0;
            res_found_q <= 1'b0;
            state_q     <= ST_DONE;
          end else if (err_ok) begin
            res_mult_q  <= cand[W-1:0];
            res_sh_q    <= SHIFT_W'(p_q);
            res_found_q <= 1'b1;
            state_q     <= ST_DONE;
          end else if (p_q == S_LAST) begin
            res_mult_q  <= '0;
            res_sh_q    <= '0;
            res_found_q <= 1'b0;
            state_q     <= ST_DONE;
          end else begin
            state_q <= ST_U_STEP;
          end
        end

        ST_U_STEP: begin
          ra_q    <= ra_next;
          qa_q    <= qa_next;
          p_q     <= p_q + P_W'(1);
          pow_q   <= {pow_q[W-2:0], 1'b0};
          state_q <= ST_U_TST;
        end

        ST_DONE: begin
          // hand over once the output register is free
          if (out_free) begin
            m_mult_q  <= DATA_W'(res_mult_q);
            m_sh_q    <= res_sh_q;
            m_found_q <= res_found_q;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready   = (state_q == ST_IDLE);
  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = {{PAD_W{1'b0}}, m_sh_q, m_mult_q};
  assign m_axis_tuser[0] = m_found_q;

endmodule

// File: sv/dmg_checker.sv
// port-level checks of the division magic number generator and their binding
`timescale 1ns / 1ps

module dmg_checker
  import dmg_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [DATA_W-1:0]      s_axis_tdata,
  input logic [0:0]             s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]             m_axis_tuser
);

  // a taken divisor leaves the divisor side not ready in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("divisor side ready right after a transaction");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised without work in progress");

  // no magic pair means multiplier and shift both zero
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("result without magic pair carries nonzero data");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind div_magic_number_gen_core dmg_checker u_dmg_checker (.*);

// File: tb/magic_result_checker.sv
// scoreboard that predicts and checks the magic multiplier results
`timescale 1ns / 1ps

module magic_result_checker
  import dmg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,
  input  logic [0:0]             s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [0:0]             m_axis_tuser,
  output int                     mismatch_cnt,
  output int                     pending_cnt,
  output int                     result_cnt,
  output int                     found_cnt
);

  localparam int unsigned PAD_W = OUT_TDATA_W - DATA_W - SHIFT_W;

  typedef struct packed {
    logic [DATA_W-1:0]  multiplier;
    logic [SHIFT_W-1:0] post_shift;
    logic               found;
  } magic_t;

  magic_t magic_q[$];

  // signed search: grow p from 31 until the quotient of 2^p by anc catches up
  function automatic magic_t signed_magic(input logic [63:0] dd);
    magic_t res;
    logic [63:0] half, anc, q1, r1, q2, r2, delta;
    int unsigned p;
    half  = 64'd1 << (DATA_W - 1);
    anc   = half - 64'd1 - (half % dd);
    p     = DATA_W - 1;
    q1    = half / anc;
    r1    = half - q1 * anc;
    q2    = half / dd;
    r2    = half - q2 * dd;
    do begin
      p++;
      q1 = q1 << 1;
      r1 = r1 << 1;
      if (r1 >= anc) begin
        q1++;
        r1 = r1 - anc;
      end
      q2 = q2 << 1;
      r2 = r2 << 1;
      if (r2 >= dd) begin
        q2++;
        r2 = r2 - dd;
      end
      delta = dd - r2;
    end while ((q1 < delta || (q1 == delta && r1 == 0)) && p < 2 * DATA_W - 1);
    res.multiplier = q2[DATA_W-1:0] + 1'b1;
    res.post_shift = SHIFT_W'(p - DATA_W);
    res.found      = 1'b1;
    return res;
  endfunction

  // unsigned: smallest shift whose rounded-up reciprocal fits and errs below 2^s
  function automatic magic_t unsigned_magic(input logic [63:0] dd);
    magic_t res;
    logic [63:0] pw, cand;
    bit done;
    res  = '0;
    done = 0;
    for (int s = 0; s < DATA_W && !done; s++) begin
      pw   = 64'd1 << (DATA_W + s);
      cand = (pw + dd - 64'd1) / dd;
      if (cand >= (64'd1 << DATA_W)) begin
        done = 1;
      end else if (cand * dd - pw < (64'd1 << s)) begin
        res.multiplier = cand[DATA_W-1:0];
        res.post_shift = SHIFT_W'(s);
        res.found      = 1'b1;
        done           = 1;
      end
    end
    return res;
  endfunction

  function automatic magic_t predict_magic(input logic sgn, input logic [DATA_W-1:0] divisor);
    logic [63:0] dd;
    dd = 64'(divisor);
    // divisors below 2 or with the top bit set have no magic pair
    if (dd < 64'd2 || dd >= (64'd1 << (DATA_W - 1))) return '0;
    return sgn ? signed_magic(dd) : unsigned_magic(dd);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    magic_t want;
    magic_t got;
    logic [PAD_W-1:0] pad;
    int errs;
    if (!rst_ni) begin
      magic_q.delete();
      mismatch_cnt <= 0;
      pending_cnt  <= 0;
      result_cnt   <= 0;
      found_cnt    <= 0;
    end else begin
      errs = 0;
      // results first, so a result never meets an expectation queued at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.multiplier = m_axis_tdata[DATA_W-1:0];
        got.post_shift = m_axis_tdata[DATA_W +: SHIFT_W];
        got.found      = m_axis_tuser[0];
        pad            = m_axis_tdata[OUT_TDATA_W-1 -: PAD_W];
        result_cnt <= result_cnt + 1;
        if (got.found) found_cnt <= found_cnt + 1;
        if (magic_q.size() == 0) begin
          $display("%0t: result with nothing expected: mult %h shift %0d found %b",
                   $time, got.multiplier, got.post_shift, got.found);
          errs++;
        end else begin
          want = magic_q.pop_front();
          if (got.multiplier !== want.multiplier) begin
            $display("%0t: multiplier expected %h actual %h", $time, want.multiplier,
                     got.multiplier);
            errs++;
          end
          if (got.post_shift !== want.post_shift) begin
            $display("%0t: post_shift expected %0d actual %0d", $time, want.post_shift,
                     got.post_shift);
            errs++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found expected %b actual %b", $time, want.found, got.found);
            errs++;
          end
          if (pad !== '0) begin
            $display("%0t: tdata padding expected 0 actual %b", $time, pad);
            errs++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        magic_q.insert(magic_q.size(), predict_magic(s_axis_tuser[0], s_axis_tdata));
      mismatch_cnt <= mismatch_cnt + errs;
      pending_cnt  <= magic_q.size();
    end
  end

endmodule

// File: tb/div_magic_number_gen_core_test.sv
// stimulus, stall control and verdict for the division magic number generator
`timescale 1ns / 1ps

module div_magic_number_gen_core_test;
  import dmg_pkg::*;

  localparam int RANDOM_ITEMS  = 930;
  localparam int QUIET_ITEMS   = 150;   // tail of the run with no idling
  localparam int HOLD_AT_ITEM  = 300;   // start of the long receiver hold-off
  localparam int HOLD_CYCLES   = 500;
  localparam int DRAIN_CYCLES  = 250;   // extra wait once no result is pending
  localparam int IDLE_LIMIT    = 5000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata;   // [31:0] divisor
  logic [0:0]             s_axis_tuser;   // [0] is_signed
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] multiplier, [36:32] post_shift, [39:37] zero
  logic [0:0]             m_axis_tuser;   // [0] found

  int mismatch_cnt, pending_cnt, result_cnt, found_cnt;
  int n_sent, n_signed, n_out_of_range;
  bit quiet, hold_go;

  div_magic_number_gen_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  magic_result_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatch_cnt  (mismatch_cnt),
    .pending_cnt   (pending_cnt),
    .result_cnt    (result_cnt),
    .found_cnt     (found_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // offer one divisor, holding tvalid high until the transaction completes
  task automatic send_divisor(input logic sgn, input logic [DATA_W-1:0] divisor);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom();
      s_axis_tuser  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= divisor;
    s_axis_tuser  <= sgn;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    if (sgn) n_signed++;
    if (divisor < 2 || divisor[DATA_W-1]) n_out_of_range++;
    if (n_sent == HOLD_AT_ITEM) hold_go = 1;
  endtask

  // mix of bit lengths so both short and long searches show up, plus
  // raw words, out-of-range values and powers of two with neighbors
  function automatic logic [DATA_W-1:0] pick_divisor();
    int unsigned sel, k;
    logic [DATA_W-1:0] pw2;
    sel = $urandom_range(0, 99);
    k   = $urandom_range(1, 30);
    pw2 = 32'd1 << k;
    if (sel < 8) return $urandom();
    if (sel < 12) return $urandom_range(0, 1);
    if (sel < 15) return {1'b1, 31'($urandom())};
    if (sel < 25) return pw2 + 32'($urandom_range(0, 2)) - 32'd1;
    k = $urandom_range(2, 31);
    return $urandom_range(2, (32'd1 << k) - 32'd1);
  endfunction

  // directed divisors, each sent in both modes
  logic [DATA_W-1:0] corner_div [12] = '{
    32'd0, 32'd1,                    // below the valid range
    32'd2, 32'd3, 32'd5, 32'd6,
    32'd7,                           // unsigned needs a 33-bit multiplier, so no magic
    32'd10, 32'h4000_0000,
    32'h7fff_ffff,                   // largest valid divisor
    32'h8000_0000, 32'hffff_ffff     // top bit set, out of range
  };

  // sender
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    n_sent        = 0;
    n_signed      = 0;
    n_out_of_range = 0;
    quiet         = 0;
    hold_go       = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_div[i]) begin
      send_divisor(1'b0, corner_div[i]);
      send_divisor(1'b1, corner_div[i]);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1;
      send_divisor(1'($urandom_range(0, 1)), pick_divisor());
    end
    s_axis_tvalid <= 1'b0;

    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d divisors (%0d signed, %0d out of range), %0d results, %0d with found set",
             n_sent, n_signed, n_out_of_range, result_cnt, found_cnt);
    $display("includes a %0d-cycle result stall with the input stream still offering",
             HOLD_CYCLES);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold-off, none in the tail
  initial begin
    bit held;
    held          = 0;
    m_axis_tready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_go && !held) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // watchdog: cycles in a row with no transaction on either stream
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
             IDLE_LIMIT, pending_cnt);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
